FILE: rtl/pud_pkg.sv
// shared types, constants and hex helpers for the percent decoder
package pud_pkg;

  localparam int unsigned BUNDLE_MAX = 3;

  localparam logic [7:0] PCT_CHAR  = 8'h25;
  localparam logic [7:0] TERM_BYTE = 8'h00;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  typedef logic [7:0] byte_t;

  // up to three result bytes produced by one input transaction
  typedef struct packed {
    logic [1:0]             cnt;
    logic                   last;
    logic [BUNDLE_MAX-1:0][7:0] bytes;
  } bundle_t;

  function automatic logic is_hex(input byte_t c);
    return ((c >= CH_0) && (c <= CH_9)) ||
           ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic [3:0] hex_value(input byte_t c);
    logic [7:0] d;
    d = 8'h00;
    if ((c >= CH_0) && (c <= CH_9)) begin
      d = c - CH_0;
    end else if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
      d = c - CH_LO_A + {4'h0, HEX_TEN};
    end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
      d = c - CH_UP_A + {4'h0, HEX_TEN};
    end
    return d[3:0];
  endfunction

endpackage

FILE: rtl/pud_in_if.sv
// input channel: encoded text bytes and end marks
interface pud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_mark;

  modport source (output valid, output in_byte, output end_mark, input ready);
  modport sink   (input valid, input in_byte, input end_mark, output ready);
endinterface

FILE: rtl/pud_out_if.sv
// result channel: decoded bytes with terminator flag
interface pud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: rtl/pud_front.sv
// front end: escape tracking and per-transaction result bundles
module pud_front
  import pud_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  pud_in_if.sink    in_ch,
  input  logic      q_full,
  output logic      q_push,
  output bundle_t   q_data
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  byte_t      held_r, held_nxt;
  logic [1:0] pcnt;
  logic       tail_v;
  byte_t      tail;
  logic       do_idle;
  logic       accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // classify the byte against the pending escape
  always_comb begin
    pcnt      = 2'd0;
    tail_v    = 1'b0;
    tail      = in_ch.in_byte;
    do_idle   = 1'b0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (in_ch.end_mark) begin
      unique case (phase_r)
        PH_PCT:   pcnt = 2'd1;
        PH_DIGIT: pcnt = 2'd2;
        default:  pcnt = 2'd0;
      endcase
      tail      = TERM_BYTE;
      tail_v    = 1'b1;
      phase_nxt = PH_IDLE;
      held_nxt  = 8'h00;
    end else begin
      unique case (phase_r)
        PH_PCT: begin
          if (is_hex(in_ch.in_byte)) begin
            held_nxt  = in_ch.in_byte;
            phase_nxt = PH_DIGIT;
          end else begin
            pcnt    = 2'd1;
            do_idle = 1'b1;
          end
        end
        PH_DIGIT: begin
          held_nxt = 8'h00;
          if (is_hex(in_ch.in_byte)) begin
            tail      = {hex_value(held_r), hex_value(in_ch.in_byte)};
            tail_v    = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            pcnt    = 2'd2;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
      // byte handled with no escape pending
      if (do_idle) begin
        if (in_ch.in_byte == PCT_CHAR) begin
          phase_nxt = PH_PCT;
        end else begin
          phase_nxt = PH_IDLE;
          tail_v    = 1'b1;
        end
      end
    end
  end

  // pack literal prefix and tail byte into one bundle
  always_comb begin
    q_data.cnt      = pcnt + {1'b0, tail_v};
    q_data.last     = in_ch.end_mark;
    q_data.bytes[0] = (pcnt == 2'd0) ? tail : PCT_CHAR;
    q_data.bytes[1] = (pcnt == 2'd2) ? held_r : tail;
    q_data.bytes[2] = tail;
    q_push          = accept && (q_data.cnt != 2'd0);
  end

  // escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

FILE: rtl/pud_fifo.sv
// small bundle queue between front and back ends
module pud_fifo
  import pud_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t wr_data,
  input  logic    pop,
  output logic    full,
  output logic    rd_valid,
  output bundle_t rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  bundle_t       mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == FULL_CNT);
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/pud_back.sv
// back end: serialises bundles into the registered result channel
module pud_back
  import pud_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  bundle_t   q_data,
  output logic      q_pop,
  pud_out_if.source out_ch
);

  bundle_t    cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       out_valid_r;
  byte_t      out_byte_r;
  logic       out_last_r;
  logic       adv;
  logic       last_elem;
  logic       load;
  byte_t      sel_byte;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

  // output slot is free when empty or being taken
  always_comb begin
    adv       = !out_valid_r || out_ch.ready;
    last_elem = (idx_r == (cur_r.cnt - 2'd1));
    load      = q_valid && (!cur_valid_r || (adv && last_elem));
    q_pop     = load;
    case (idx_r)
      2'd0:    sel_byte = cur_r.bytes[0];
      2'd1:    sel_byte = cur_r.bytes[1];
      default: sel_byte = cur_r.bytes[2];
    endcase
  end

  // control: bundle occupancy, element index, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= cur_valid_r;
        if (cur_valid_r) begin
          idx_r <= idx_r + 2'd1;
        end
      end
      if (load) begin
        cur_valid_r <= 1'b1;
        idx_r       <= 2'd0;
      end else if (adv && cur_valid_r && last_elem) begin
        cur_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_data;
    end
    if (adv && cur_valid_r) begin
      out_byte_r <= sel_byte;
      out_last_r <= cur_r.last && last_elem;
    end
  end

endmodule

FILE: rtl/url_percent_decoder_core.sv
// top level of the streaming url percent decoder
//
// in_ch carries one encoded byte (in_byte) or an end mark (end_mark) per
// transaction; out_ch carries decoded bytes, with out_last set on the zero
// terminator that closes each string. A '%' and two hex digits (either case)
// become one byte; a broken escape is passed through literally.
// Throughput: one input transaction per cycle while the bundle queue has
// room. Each input gives zero to three result bytes, and the back end sends
// one result per cycle while out_ch is ready, so a run of inputs that each
// give more than one result is limited by the single result port and backs
// up in the queue. A result passes through the queue, the bundle register
// and the output register, in that order, before it reaches out_ch; it
// waits longer if results queue.
// When out_ch stalls the output register holds, the queue fills and
// in_ch.ready drops once QUEUE_DEPTH bundles are waiting; nothing is lost or
// repeated.
// Reset (rst_n low, synchronous) clears the escape state, empties the queue
// and drops out_ch.valid; there is no clearing pass.
module url_percent_decoder_core
  import pud_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  pud_in_if.sink    in_ch,
  pud_out_if.source out_ch
);

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_valid;
  bundle_t q_wr_data;
  bundle_t q_rd_data;

  // classify and build bundles
  pud_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  // decouple the two ends
  pud_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (q_wr_data),
    .pop      (q_pop),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  // emit one result per cycle while out_ch is ready
  pud_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // the terminator is always a zero byte
  a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_last |-> out_ch.out_byte == TERM_BYTE)
    else $error("terminator carries a non-zero byte");

  // the front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("bundle queue overflow");

  // the back never reads an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("bundle queue underflow");

  // reset leaves no result pending
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule
